FILE: rtl/core/pva_pkg.sv
package pva_pkg;

    // Command codes of an input transaction.
    localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
    localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
    localparam logic [1:0] CMD_RELEASED = 2'd2;

    // Action codes of a result transaction.
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_START   = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_REMOVED = 2'd3;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    localparam logic [7:0] MIDI_MAX = 8'd127;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] note;
        logic [7:0] velocity;
        logic [2:0] voice_index;
    } t_in_item;

    typedef struct packed {
        logic       status;
        logic [1:0] action;
        logic [2:0] voice_slot;
        logic [6:0] voice_note;
        logic [6:0] voice_velocity;
        logic [3:0] active_count;
    } t_out_item;

    // One entry of the voice table. Only valid MIDI values are ever stored.
    typedef struct packed {
        logic [6:0] note;
        logic [6:0] velocity;
    } t_slot;

endpackage

FILE: rtl/core/polyphonic_voice_allocator.sv
// Polyphonic voice allocator. A command transaction is taken at a rising edge where start is
// high and busy is low, and it always produces exactly one result transaction, shown on
// o_result for a single cycle with o_done high; the receiver cannot stall, so it must take
// every result in that cycle. For a note-on, an invalid command, an argument error or a
// note-off on an empty table, the result appears in the next cycle and busy never rises, so
// commands of that kind may follow back to back. A note-off walks the voice table through
// the single read port of the table memory, one slot per cycle, and holds busy until the
// note is found or the top active slot has been compared. A release-finished command reads
// the named voice and then every later one, writing each back one slot lower, and holds
// busy until the top active slot has been moved. After reset the table is empty; no clearing
// pass is needed because only slots below the active count are ever read.
module polyphonic_voice_allocator #(
    parameter int VOICES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  pva_pkg::t_in_item  i_item,
    output logic               o_done,
    output pva_pkg::t_out_item o_result
);

    // Slot address width, and a count width that can also hold VOICES itself.
    localparam int IW   = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW   = $clog2(VOICES + 1);
    localparam int CMPW = CW + 3;
    localparam logic [CW-1:0] FULL_COUNT = CW'(VOICES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

    t_state             r_state, n_state;
    pva_pkg::t_in_item  r_item, n_item;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_ptr, n_ptr;
    logic               r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]      r_cmp_slot, n_cmp_slot;
    pva_pkg::t_slot     r_old, n_old;
    logic               r_done, n_done;
    pva_pkg::t_out_item r_result, n_result;

    // Table memory port signals.
    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    pva_pkg::t_slot     mem_wdata;
    logic               mem_re;
    logic [IW-1:0]      mem_raddr;
    pva_pkg::t_slot     mem_rdata;

    pva_pkg::t_out_item res;
    logic               last_slot;
    logic               first_slot;

    pva_slot_ram #(
        .DEPTH (VOICES),
        .AW    (IW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The slot whose data is arriving is the top active one.
    assign last_slot  = (CW'(r_cmp_slot) + CW'(1)) == r_count;
    // During a removal, the slot whose data is arriving is the one being removed.
    assign first_slot = r_cmp_slot == IW'(r_item.voice_index);

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_cmp_vld  = 1'b0;
        n_cmp_slot = r_cmp_slot;
        n_old      = r_old;
        n_done     = 1'b0;
        n_result   = r_result;
        mem_we     = 1'b0;
        mem_waddr  = r_cmp_slot - IW'(1);
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = r_ptr[IW-1:0];
        res        = '0;

        // Both walks issue one read per cycle until every active slot has been requested;
        // the read data is registered and comes back tagged by r_cmp_slot.
        if (r_state != S_IDLE && r_ptr < r_count) begin
            mem_re     = 1'b1;
            n_ptr      = r_ptr + CW'(1);
            n_cmp_vld  = 1'b1;
            n_cmp_slot = r_ptr[IW-1:0];
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    unique case (i_item.cmd)
                        pva_pkg::CMD_NOTE_ON: begin
                            n_done = 1'b1;
                            if (i_item.note > pva_pkg::MIDI_MAX ||
                                i_item.velocity > pva_pkg::MIDI_MAX) begin
                                res.status = pva_pkg::STATUS_INVALID;
                            end else if (r_count < FULL_COUNT) begin
                                // Append at the top of the compacted table.
                                mem_we             = 1'b1;
                                mem_waddr          = IW'(r_count);
                                mem_wdata.note     = i_item.note[6:0];
                                mem_wdata.velocity = i_item.velocity[6:0];
                                n_count            = r_count + CW'(1);
                                res.action         = pva_pkg::ACT_START;
                                res.voice_slot     = 3'(r_count);
                                res.voice_note     = i_item.note[6:0];
                                res.voice_velocity = i_item.velocity[6:0];
                            end
                        end
                        pva_pkg::CMD_NOTE_OFF: begin
                            if (i_item.note > pva_pkg::MIDI_MAX) begin
                                n_done     = 1'b1;
                                res.status = pva_pkg::STATUS_INVALID;
                            end else if (r_count == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        pva_pkg::CMD_RELEASED: begin
                            if (CMPW'(i_item.voice_index) >= CMPW'(r_count)) begin
                                n_done     = 1'b1;
                                res.status = pva_pkg::STATUS_INVALID;
                            end else begin
                                n_ptr   = CW'(i_item.voice_index);
                                n_state = S_SHIFT;
                            end
                        end
                        default: begin
                            n_done     = 1'b1;
                            res.status = pva_pkg::STATUS_INVALID;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_cmp_vld) begin
                    if ({1'b0, mem_rdata.note} == r_item.note) begin
                        n_done             = 1'b1;
                        n_state            = S_IDLE;
                        res.action         = pva_pkg::ACT_RELEASE;
                        res.voice_slot     = 3'(r_cmp_slot);
                        res.voice_note     = mem_rdata.note;
                        res.voice_velocity = mem_rdata.velocity;
                    end else if (last_slot) begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_SHIFT: begin
                if (r_cmp_vld) begin
                    // The removed voice is kept for the result; every later voice moves
                    // down one slot. A slot is always read before it is overwritten.
                    if (first_slot) begin
                        n_old = mem_rdata;
                    end else begin
                        mem_we = 1'b1;
                    end
                    if (last_slot) begin
                        n_done             = 1'b1;
                        n_state            = S_IDLE;
                        n_count            = r_count - CW'(1);
                        res.action         = pva_pkg::ACT_REMOVED;
                        res.voice_slot     = r_item.voice_index;
                        res.voice_note     = first_slot ? mem_rdata.note : r_old.note;
                        res.voice_velocity = first_slot ? mem_rdata.velocity
                                                        : r_old.velocity;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        res.active_count = 4'(n_count);
        if (n_done) begin
            n_result = res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_ptr      <= n_ptr;
        r_cmp_slot <= n_cmp_slot;
        r_old      <= n_old;
        r_result   <= n_result;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            r_done    <= n_done;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("active voice count exceeds the table size");

    a_none_is_blank : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.action == pva_pkg::ACT_NONE |->
            o_result.voice_slot == '0 && o_result.voice_note == '0 &&
            o_result.voice_velocity == '0)
        else $error("result without an action carries slot data");

    a_note_on_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.cmd == pva_pkg::CMD_NOTE_ON |=> o_done && !busy)
        else $error("note-on did not complete in one cycle");

    a_walk_ends_in_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_done)
        else $error("table walk finished without a result transaction");

    a_write_idle_only_note_on : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we && !busy |-> start && i_item.cmd == pva_pkg::CMD_NOTE_ON)
        else $error("table written while idle without a note-on");
`endif

endmodule

FILE: rtl/core/pva_slot_ram.sv
// Voice table storage: one write port, one read port, registered read data.
module pva_slot_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  pva_pkg::t_slot i_wdata,
    input  logic           i_re,
    input  logic [AW-1:0]  i_raddr,
    output pva_pkg::t_slot o_rdata
);

    pva_pkg::t_slot r_mem [DEPTH];
    pva_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/pva_result_checker.sv
module pva_result_checker #(
    parameter int VOICES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  pva_pkg::t_in_item  i_item,
    input  logic               i_done,
    input  pva_pkg::t_out_item i_result,
    output int                 o_failures,
    output int                 o_pending,
    output int                 o_checked,
    output logic [3:0]         o_voice_count
);

    timeunit 1ns;
    timeprecision 1ps;

    // Our own copy of the voice table; 8'hFF marks a free slot.
    logic [7:0]         held_note [VOICES];
    logic [6:0]         held_velocity [VOICES];
    logic [3:0]         voices_in_use;
    pva_pkg::t_out_item awaited_results [$];
    int                 failures = 0;
    int                 checked = 0;

    // Applies one command to the table copy and returns the result it must produce.
    function automatic pva_pkg::t_out_item play_command(input pva_pkg::t_in_item cmd_item);
        pva_pkg::t_out_item res;
        int                 idx;
        bit                 found;
        res = '0;
        res.status = pva_pkg::STATUS_OK;
        res.action = pva_pkg::ACT_NONE;
        found = 1'b0;
        case (cmd_item.cmd)
            pva_pkg::CMD_NOTE_ON: begin
                if (cmd_item.note > pva_pkg::MIDI_MAX ||
                    cmd_item.velocity > pva_pkg::MIDI_MAX) begin
                    res.status = pva_pkg::STATUS_INVALID;
                end else if (voices_in_use < VOICES) begin
                    idx = voices_in_use;
                    held_note[idx] = cmd_item.note;
                    held_velocity[idx] = cmd_item.velocity[6:0];
                    voices_in_use = voices_in_use + 4'd1;
                    res.action = pva_pkg::ACT_START;
                    res.voice_slot = idx[2:0];
                    res.voice_note = cmd_item.note[6:0];
                    res.voice_velocity = cmd_item.velocity[6:0];
                end
            end
            pva_pkg::CMD_NOTE_OFF: begin
                if (cmd_item.note > pva_pkg::MIDI_MAX) begin
                    res.status = pva_pkg::STATUS_INVALID;
                end else begin
                    for (idx = 0; idx < voices_in_use && !found; idx++) begin
                        if (held_note[idx] == cmd_item.note) begin
                            found = 1'b1;
                            res.action = pva_pkg::ACT_RELEASE;
                            res.voice_slot = idx[2:0];
                            res.voice_note = held_note[idx][6:0];
                            res.voice_velocity = held_velocity[idx];
                        end
                    end
                end
            end
            pva_pkg::CMD_RELEASED: begin
                if (cmd_item.voice_index >= voices_in_use) begin
                    res.status = pva_pkg::STATUS_INVALID;
                end else begin
                    res.action = pva_pkg::ACT_REMOVED;
                    res.voice_slot = cmd_item.voice_index;
                    res.voice_note = held_note[cmd_item.voice_index][6:0];
                    res.voice_velocity = held_velocity[cmd_item.voice_index];
                    voices_in_use = voices_in_use - 4'd1;
                    for (idx = cmd_item.voice_index; idx < voices_in_use; idx++) begin
                        held_note[idx] = held_note[idx + 1];
                        held_velocity[idx] = held_velocity[idx + 1];
                    end
                    held_note[voices_in_use] = 8'hFF;
                    held_velocity[voices_in_use] = '0;
                end
            end
            default: begin
                res.status = pva_pkg::STATUS_INVALID;
            end
        endcase
        res.active_count = voices_in_use;
        return res;
    endfunction

    function automatic int field_mismatch(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : monitor
        pva_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < VOICES; i++) begin
                held_note[i] = 8'hFF;
                held_velocity[i] = '0;
            end
            voices_in_use = '0;
            awaited_results.delete();
        end else begin
            // A result is checked before the command taken at the same edge is queued.
            if (i_done) begin
                checked++;
                if (awaited_results.size() == 0) begin
                    $error("Result transaction with nothing outstanding: %p", i_result);
                    failures++;
                end else begin
                    want = awaited_results.pop_front();
                    failures += field_mismatch("status", want.status, i_result.status);
                    failures += field_mismatch("action", want.action, i_result.action);
                    failures += field_mismatch("voice_slot", want.voice_slot,
                                               i_result.voice_slot);
                    failures += field_mismatch("voice_note", want.voice_note,
                                               i_result.voice_note);
                    failures += field_mismatch("voice_velocity", want.voice_velocity,
                                               i_result.voice_velocity);
                    failures += field_mismatch("active_count", want.active_count,
                                               i_result.active_count);
                end
            end
            if (i_start && !i_busy) begin
                awaited_results.push_back(play_command(i_item));
            end
        end
        o_failures <= failures;
        o_pending <= awaited_results.size();
        o_checked <= checked;
        o_voice_count <= voices_in_use;
    end

endmodule

FILE: tb/polyphonic_voice_allocator_tb.sv
module polyphonic_voice_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // The package names only the three legal commands; the fourth code must be refused.
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    localparam int VOICES = 8;
    localparam int RANDOM_COMMANDS = 800;
    // The final stretch of the random part runs without any idling on the sender side.
    localparam int CALM_TAIL = 100;
    // Idle time at the end, long enough to cover a straggler from the slowest command.
    localparam int SETTLE_CYCLES = 12;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    pva_pkg::t_in_item  i_item = '0;
    logic               o_done;
    pva_pkg::t_out_item o_result;

    int         failures;
    int         pending;
    int         checked;
    logic [3:0] voices_predicted;
    int         sent_by_cmd [4];

    polyphonic_voice_allocator #(
        .VOICES (VOICES)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // The checker sits beside the block, watches both channels and keeps the scoreboard;
    // this module only produces stimulus and delivers the verdict.
    pva_result_checker #(
        .VOICES (VOICES)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_item        (i_item),
        .i_done        (o_done),
        .i_result      (o_result),
        .o_failures    (failures),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_voice_count (voices_predicted)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Presents one command and returns at the edge where the transaction is taken. Start is
    // left high so that the next command can follow back to back; the caller lowers it when
    // the sender is to idle.
    task automatic issue(input logic [1:0] cmd, input logic [7:0] note,
                         input logic [7:0] velocity, input logic [2:0] voice_index);
        pva_pkg::t_in_item item;
        item.cmd = cmd;
        item.note = note;
        item.velocity = velocity;
        item.voice_index = voice_index;
        start <= 1'b1;
        i_item <= item;
        do @(posedge i_clk); while (busy);
        sent_by_cmd[cmd]++;
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Waits until every result owed has arrived. The checker's count is registered, hence
    // the first edge is always spent.
    task automatic wait_for_quiet();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic on a narrow band of notes, so that note-offs find their
    // voices and the table fills and empties often. Release indexes are drawn below the
    // checker's current voice count; that count may trail the command just taken by one, which
    // now and then yields an out-of-range release as a useful side effect. A small share of
    // commands is pure noise over the whole width of every field.
    task automatic issue_random(input bit filling);
        int         roll;
        int         weight_on;
        logic [1:0] cmd;
        logic [7:0] note;
        logic [7:0] velocity;
        logic [2:0] voice_index;
        roll = $urandom_range(0, 99);
        weight_on = filling ? 55 : 25;
        note = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 127))
                                           : 8'($urandom_range(56, 67));
        velocity = 8'($urandom_range(0, 127));
        voice_index = (voices_predicted != 0) ? 3'($urandom_range(0, voices_predicted - 1))
                                              : 3'($urandom);
        if (roll < 6) begin
            cmd = 2'($urandom);
            note = 8'($urandom);
            velocity = 8'($urandom);
            voice_index = 3'($urandom);
        end else if (roll < 6 + weight_on) begin
            cmd = pva_pkg::CMD_NOTE_ON;
        end else if (roll < 6 + weight_on + 22) begin
            cmd = pva_pkg::CMD_NOTE_OFF;
        end else begin
            cmd = pva_pkg::CMD_RELEASED;
        end
        issue(cmd, note, velocity, voice_index);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. On an empty table a release must be refused and a note-off must
        // find nothing.
        issue(pva_pkg::CMD_RELEASED, 8'd0, 8'd0, 3'd0);
        issue(pva_pkg::CMD_NOTE_OFF, 8'd60, 8'd0, 3'd0);
        // The lowest and highest legal values, then each way a note-on can be malformed.
        issue(pva_pkg::CMD_NOTE_ON, 8'd0, 8'd0, 3'd0);
        issue(pva_pkg::CMD_NOTE_ON, 8'd127, 8'd127, 3'd7);
        issue(pva_pkg::CMD_NOTE_ON, 8'd128, 8'd0, 3'd0);
        issue(pva_pkg::CMD_NOTE_ON, 8'd0, 8'd128, 3'd0);
        issue(pva_pkg::CMD_NOTE_ON, 8'd255, 8'd255, 3'd7);
        issue(CMD_UNKNOWN, 8'd64, 8'd64, 3'd2);
        // Fill the remaining six slots; slot four repeats note zero so that a note-off has
        // two candidates and must pick the lower slot.
        issue(pva_pkg::CMD_NOTE_ON, 8'd60, 8'd100, 3'd0);
        issue(pva_pkg::CMD_NOTE_ON, 8'd61, 8'd101, 3'd0);
        issue(pva_pkg::CMD_NOTE_ON, 8'd0, 8'd90, 3'd0);
        issue(pva_pkg::CMD_NOTE_ON, 8'd63, 8'd103, 3'd0);
        issue(pva_pkg::CMD_NOTE_ON, 8'd64, 8'd104, 3'd0);
        issue(pva_pkg::CMD_NOTE_ON, 8'd65, 8'd1, 3'd0);
        // The table is full now, so this note is dropped without a start.
        issue(pva_pkg::CMD_NOTE_ON, 8'd66, 8'd66, 3'd0);
        issue(pva_pkg::CMD_NOTE_OFF, 8'd127, 8'd0, 3'd0);
        issue(pva_pkg::CMD_NOTE_OFF, 8'd0, 8'd0, 3'd0);
        issue(pva_pkg::CMD_NOTE_OFF, 8'd255, 8'd0, 3'd0);
        issue(pva_pkg::CMD_NOTE_OFF, 8'd50, 8'd0, 3'd0);
        // Remove the top voice, then the bottom one with a full shift, then try one index
        // past the end, then remove the last voice.
        issue(pva_pkg::CMD_RELEASED, 8'd0, 8'd0, 3'd7);
        issue(pva_pkg::CMD_RELEASED, 8'd0, 8'd0, 3'd0);
        issue(pva_pkg::CMD_RELEASED, 8'd0, 8'd0, 3'd6);
        issue(pva_pkg::CMD_RELEASED, 8'd0, 8'd0, 3'd5);

        // The sender waits for the block to fall completely quiet before the random part.
        wait_for_quiet();

        // Random part. The mix swings between filling and draining the table every eighty
        // commands, so that the full table and the empty table are both visited repeatedly.
        for (int n = 0; n < RANDOM_COMMANDS; n++) begin
            issue_random(((n / 80) % 2) == 0);
            if (n == RANDOM_COMMANDS / 2) begin
                wait_for_quiet();
            end else if (n < RANDOM_COMMANDS - CALM_TAIL && $urandom_range(0, 2) == 0) begin
                hold_off($urandom_range(1, 9));
            end
        end

        wait_for_quiet();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d note-on, %0d note-off, %0d release-finished and %0d unknown commands.",
                 sent_by_cmd[pva_pkg::CMD_NOTE_ON], sent_by_cmd[pva_pkg::CMD_NOTE_OFF],
                 sent_by_cmd[pva_pkg::CMD_RELEASED], sent_by_cmd[CMD_UNKNOWN]);
        $display("Compared %0d result transactions against the voice table prediction.",
                 checked);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Safety net against a hung handshake; a correct run ends far sooner.
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
